// ===== rtl/disc_sector_locator_macros.svh =====
// Assertion macros shared by the locator RTL.
`ifndef DISC_SECTOR_LOCATOR_MACROS_SVH
`define DISC_SECTOR_LOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define DSL_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("disc_sector_locator: check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define DSL_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("disc_sector_locator: check failed");

`endif

// ===== rtl/dsl_pkg.sv =====
package dsl_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_XLATE = 1'b1;

  localparam int FramesPerSec = 75;
  localparam int FramesPerMin = 4500;

  localparam logic [11:0] RAW_LEN  = 12'd2352;
  localparam logic [11:0] PAY_LEN  = 12'd2048;
  localparam logic [4:0]  PAY_POS  = 5'd24;
  localparam logic [4:0]  RAW_POS  = 5'd0;

  typedef struct packed {
    logic        raw;
    logic [11:0] stride;
    logic [35:0] base;
    logic [18:0] count;
    logic [18:0] first;
  } slot_t;

  typedef struct packed {
    logic [7:0] minute;
    logic [6:0] second;
    logic [6:0] frame;
  } hdr_t;

endpackage

// ===== rtl/disc_sector_locator.sv =====
// Channel   | Handshake       | Beat
// ----------+-----------------+--------------------------------------------
// request   | start / busy    | opcode_i, slot_index_i .. sector_number_i
// result    | done_o strobe   | found_o, read_offset_o .. header_frame_o
//
// A slot write's result beat follows on the next cycle.
// A lookup scans the slot table until a hit or the last slot, then waits for
// the header divider sequence to finish before its result beat.
// The slot scan reads one table entry per cycle through the registered port.
// Reset clears the used marks at once; no clearing pass is needed.
// Results cannot be stalled; during a lookup busy stays high until the result beat.
`include "disc_sector_locator_macros.svh"

module disc_sector_locator #(
  parameter int TRACK_SLOTS = 128,
  parameter int LEAD_IN     = 150
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        opcode_i,
  input  logic [6:0]  slot_index_i,
  input  logic        slot_valid_i,
  input  logic [18:0] first_sector_i,
  input  logic [18:0] sector_total_i,
  input  logic [35:0] byte_base_i,
  input  logic [11:0] sector_stride_i,
  input  logic        holds_raw_i,
  input  logic [18:0] sector_number_i,
  output logic        done_o,
  output logic        found_o,
  output logic [35:0] read_offset_o,
  output logic [11:0] read_length_o,
  output logic [4:0]  buffer_position_o,
  output logic        make_header_o,
  output logic [7:0]  header_minute_o,
  output logic [6:0]  header_second_o,
  output logic [6:0]  header_frame_o
);
  import dsl_pkg::*;

  localparam int Aw = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int Cw = $clog2(TRACK_SLOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_SUM  = 2'd3;

  logic [1:0]    state_q;
  logic [Cw-1:0] issue_q;
  logic          dv_q, dvlast_q, hit_q;
  logic [18:0]   sector_q, dist_q;
  logic [11:0]   stride_q;
  logic [35:0]   base_q;
  logic          raw_q;
  logic [30:0]   prod_q;

  logic          done_q, found_q, mkhdr_q;
  logic [35:0]   offset_q;
  logic [11:0]   length_q;
  logic [4:0]    bufpos_q;
  hdr_t          hdrout_q;

  logic          accept, we, re, hit, msf_idle;
  slot_t         wslot, rslot;
  logic          rused;
  logic [19:0]   range_end;
  hdr_t          hdr;

  assign accept = start && !busy;
  assign we     = accept && (opcode_i == OP_WRITE)
                  && (8'(slot_index_i) < 8'(TRACK_SLOTS));
  assign re     = (state_q == ST_SCAN) && (issue_q < Cw'(TRACK_SLOTS));

  always_comb begin
    wslot.raw    = holds_raw_i;
    wslot.stride = sector_stride_i;
    wslot.base   = byte_base_i;
    wslot.count  = sector_total_i;
    wslot.first  = first_sector_i;
  end

  dsl_table #(
    .Slots (TRACK_SLOTS),
    .Aw    (Aw)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (slot_index_i[Aw-1:0]),
    .wused_i (slot_valid_i),
    .wdata_i (wslot),
    .re_i    (re),
    .raddr_i (issue_q[Aw-1:0]),
    .rused_o (rused),
    .rdata_o (rslot)
  );

  dsl_msf u_msf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && (opcode_i == OP_XLATE)),
    .abs_i   (20'(sector_number_i) + 20'(LEAD_IN)),
    .idle_o  (msf_idle),
    .hdr_o   (hdr)
  );

  assign range_end = {1'b0, rslot.first} + {1'b0, rslot.count};
  assign hit       = dv_q && rused && (sector_q >= rslot.first)
                     && ({1'b0, sector_q} < range_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issue_q  <= '0;
      dv_q     <= 1'b0;
      dvlast_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          issue_q <= '0;
          dv_q    <= 1'b0;
          if (accept) begin
            if (opcode_i == OP_XLATE) begin
              state_q <= ST_SCAN;
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (re) begin
            issue_q  <= issue_q + Cw'(1);
            dv_q     <= 1'b1;
            dvlast_q <= issue_q == Cw'(TRACK_SLOTS - 1);
          end else begin
            dv_q <= 1'b0;
          end
          if (hit) begin
            state_q <= ST_MUL;
          end else if (dv_q && dvlast_q) begin
            state_q <= ST_SUM;
          end
        end
        ST_MUL: begin
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          if (msf_idle) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      sector_q <= sector_number_i;
      hit_q    <= 1'b0;
    end
    if (state_q == ST_SCAN && hit) begin
      hit_q    <= 1'b1;
      dist_q   <= sector_q - rslot.first;
      stride_q <= rslot.stride;
      base_q   <= rslot.base;
      raw_q    <= rslot.raw;
    end
    if (state_q == ST_MUL) begin
      prod_q <= 31'(dist_q) * 31'(stride_q);
    end

    if (state_q == ST_IDLE && accept && opcode_i == OP_WRITE) begin
      found_q  <= 1'b0;
      offset_q <= '0;
      length_q <= '0;
      bufpos_q <= '0;
      mkhdr_q  <= 1'b0;
      hdrout_q <= '0;
    end else if (state_q == ST_SUM && msf_idle) begin
      found_q  <= hit_q;
      offset_q <= hit_q ? (base_q + 36'(prod_q)) : '0;
      length_q <= !hit_q ? '0 : (raw_q ? RAW_LEN : PAY_LEN);
      bufpos_q <= (hit_q && !raw_q) ? PAY_POS : RAW_POS;
      mkhdr_q  <= hit_q && !raw_q;
      hdrout_q <= (hit_q && !raw_q) ? hdr : '0;
    end
  end

  assign busy              = state_q != ST_IDLE;
  assign done_o            = done_q;
  assign found_o           = found_q;
  assign read_offset_o     = offset_q;
  assign read_length_o     = length_q;
  assign buffer_position_o = bufpos_q;
  assign make_header_o     = mkhdr_q;
  assign header_minute_o   = hdrout_q.minute;
  assign header_second_o   = hdrout_q.second;
  assign header_frame_o    = hdrout_q.frame;

  `DSL_ASSERT_NOW(a_hdr_needs_hit, done_o && make_header_o, found_o)
  `DSL_ASSERT_NOW(a_len_matches_kind, done_o && found_o,
    (read_length_o == RAW_LEN && buffer_position_o == RAW_POS && !make_header_o) ||
    (read_length_o == PAY_LEN && buffer_position_o == PAY_POS && make_header_o))
  `DSL_ASSERT_NOW(a_miss_is_zero, done_o && !found_o,
    read_offset_o == '0 && read_length_o == '0 && header_minute_o == '0)
  `DSL_ASSERT_NEXT(a_lookup_holds_busy, start && !busy && opcode_i == OP_XLATE,
    busy && !done_o)

endmodule

// ===== rtl/dsl_table.sv =====
module dsl_table #(
  parameter int Slots = 128,
  parameter int Aw    = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [Aw-1:0]   waddr_i,
  input  logic            wused_i,
  input  dsl_pkg::slot_t  wdata_i,
  input  logic            re_i,
  input  logic [Aw-1:0]   raddr_i,
  output logic            rused_o,
  output dsl_pkg::slot_t  rdata_o
);
  import dsl_pkg::*;

  logic  used_q [Slots];
  slot_t mem_q  [Slots];
  slot_t rdata_q;
  logic  rused_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        used_q[i] <= 1'b0;
      end
      rused_q <= 1'b0;
    end else begin
      if (we_i) begin
        used_q[waddr_i] <= wused_i;
      end
      if (re_i) begin
        rused_q <= used_q[raddr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rused_o = rused_q;
  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dsl_msf.sv =====
module dsl_msf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [19:0]   abs_i,
  output logic          idle_o,
  output dsl_pkg::hdr_t hdr_o
);
  import dsl_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_MIN  = 3'd1;
  localparam logic [2:0] PH_SEC  = 3'd2;
  localparam logic [2:0] PH_BM   = 3'd3;
  localparam logic [2:0] PH_BS   = 3'd4;
  localparam logic [2:0] PH_BF   = 3'd5;

  localparam logic [19:0] DVS_MIN = 20'(FramesPerMin * 64);
  localparam logic [19:0] DVS_SEC = 20'(FramesPerSec * 32);
  localparam logic [19:0] DVS_BCD = 20'(10 * 8);

  logic [2:0]  phase_q, phase_d;
  logic [19:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [6:0]  quo_q, quo_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [6:0]  min_q, min_d, frm_q, frm_d;
  logic [5:0]  sec_q, sec_d;
  hdr_t        hdr_q, hdr_d;

  logic        ge;
  logic [19:0] diff, r_nx;
  logic [6:0]  q_nx;

  // shared compare-subtract step
  assign ge   = rem_q >= dvs_q;
  assign diff = rem_q - dvs_q;
  assign r_nx = ge ? diff : rem_q;
  assign q_nx = {quo_q[5:0], ge};

  always_comb begin
    phase_d = phase_q;
    rem_d   = r_nx;
    dvs_d   = dvs_q >> 1;
    quo_d   = q_nx;
    cnt_d   = cnt_q - 3'd1;
    min_d   = min_q;
    sec_d   = sec_q;
    frm_d   = frm_q;
    hdr_d   = hdr_q;
    unique case (phase_q)
      PH_IDLE: begin
        rem_d = abs_i;
        dvs_d = DVS_MIN;
        quo_d = '0;
        cnt_d = 3'd6;
        if (start_i) begin
          phase_d = PH_MIN;
        end
      end
      PH_MIN: begin
        if (cnt_q == 3'd0) begin
          min_d   = q_nx;
          dvs_d   = DVS_SEC;
          quo_d   = '0;
          cnt_d   = 3'd5;
          phase_d = PH_SEC;
        end
      end
      PH_SEC: begin
        if (cnt_q == 3'd0) begin
          sec_d   = q_nx[5:0];
          frm_d   = r_nx[6:0];
          rem_d   = 20'(min_q);
          dvs_d   = DVS_BCD;
          quo_d   = '0;
          cnt_d   = 3'd3;
          phase_d = PH_BM;
        end
      end
      PH_BM: begin
        if (cnt_q == 3'd0) begin
          hdr_d.minute = {q_nx[3:0], r_nx[3:0]};
          rem_d   = 20'(sec_q);
          dvs_d   = DVS_BCD;
          quo_d   = '0;
          cnt_d   = 3'd3;
          phase_d = PH_BS;
        end
      end
      PH_BS: begin
        if (cnt_q == 3'd0) begin
          hdr_d.second = {q_nx[2:0], r_nx[3:0]};
          rem_d   = 20'(frm_q);
          dvs_d   = DVS_BCD;
          quo_d   = '0;
          cnt_d   = 3'd3;
          phase_d = PH_BF;
        end
      end
      PH_BF: begin
        if (cnt_q == 3'd0) begin
          hdr_d.frame = {q_nx[2:0], r_nx[3:0]};
          phase_d = PH_IDLE;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    min_q <= min_d;
    sec_q <= sec_d;
    frm_q <= frm_d;
    hdr_q <= hdr_d;
  end

  assign idle_o = phase_q == PH_IDLE;
  assign hdr_o  = hdr_q;

endmodule
